@@ hdl/emcu_pkg.sv @@
// Shared widths, types, register codes and the fixed-point rescale for the melt cell update.
package emcu_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int WORD_W      = 32;
  localparam int CAP_W       = 31;
  localparam int FRAC_W      = FRAC_BITS + 1;
  localparam int PROD_W      = 2 * WORD_W + 1;
  localparam int RATIO_W     = 2 * CAP_W;
  localparam int QUOT_W      = RATIO_W - FRAC_BITS;
  localparam int SQ_W        = 2 * FRAC_W;
  localparam int IDX_W       = 3;

  localparam int ENTH_STAGES = 4;
  localparam int FRAC_STAGES = 2;
  localparam int UPD_STAGES  = 4;
  localparam int NUM_STAGES  = ENTH_STAGES + FRAC_STAGES + UPD_STAGES;

  localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CAP_W-1:0]  CAP_ONE  = CAP_W'(FRAC_ONE);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [RATIO_W-1:0]       ratio_t;
  typedef logic [QUOT_W-1:0]        quot_t;
  typedef logic [SQ_W-1:0]          sq_t;

  typedef enum logic [IDX_W-1:0] {
    REG_CAP_LIQ    = 3'd0,
    REG_CAP_SOL    = 3'd1,
    REG_LATENT     = 3'd2,
    REG_INV_LATENT = 3'd3,
    REG_SOLIDUS    = 3'd4,
    REG_GAIN       = 3'd5,
    REG_MODE       = 3'd6,
    REG_DRAG       = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [CAP_W-1:0] cap_liq;
    logic [CAP_W-1:0] cap_sol;
    logic [CAP_W-1:0] latent;
    logic [CAP_W-1:0] inv_latent;
    word_t            solidus;
    word_t            gain;
    logic             mode;
    logic             drag;
  } cfg_t;

  typedef enum logic [1:0] {
    FR_ZERO   = 2'd0,
    FR_FULL   = 2'd1,
    FR_INTERP = 2'd2
  } frac_sel_e;

  // Per-cell payload that rides alongside the enthalpy math
  typedef struct packed {
    logic [FRAC_W-1:0] fold;
    word_t             src;
    word_t [2:0]       force_in;
    word_t [2:0]       vel;
  } cell_t;

  // Floor shift by FRAC_BITS, then wrap to the word width
  function automatic word_t fix_rescale(prod_t p);
    return word_t'(p[FRAC_BITS +: WORD_W]);
  endfunction

endpackage

@@ hdl/emcu_enthalpy.sv @@
// Stages 1-4: capacity select, enthalpy products, enthalpy sum and phase classification.
module emcu_enthalpy (
  input  logic                                 clk_i,
  input  logic [emcu_pkg::ENTH_STAGES-1:0]     adv_i,
  input  emcu_pkg::cfg_t                       cfg_i,
  input  emcu_pkg::word_t                      temperature_i,
  input  emcu_pkg::cell_t                      cell_i,
  output emcu_pkg::frac_sel_e                  sel_o,
  output logic [emcu_pkg::CAP_W-1:0]           excess_o,
  output emcu_pkg::cell_t                      cell_o
);

  // stage 1
  logic signed [emcu_pkg::WORD_W:0] t_ext, ts_ext, tdiff;
  logic [emcu_pkg::CAP_W-1:0]       s1_cap_d, s1_cap_q;
  logic signed [emcu_pkg::WORD_W:0] s1_mul_d, s1_mul_q;
  logic                             s1_add_hs_d, s1_add_hs_q;
  emcu_pkg::cell_t                  s1_cell_q;

  // stage 2
  logic [emcu_pkg::CAP_W-1:0] hs_cap;
  emcu_pkg::prod_t            h_prod, hs_prod, lf_prod;
  emcu_pkg::word_t            s2_h_q, s2_hs_q, s2_lf_q;
  logic                       s2_add_hs_q;
  emcu_pkg::cell_t            s2_cell_q;

  // stage 3
  emcu_pkg::word_t hs_part, s3_h_d, s3_hl_d;
  emcu_pkg::word_t s3_h_q, s3_hs_q, s3_hl_q;
  emcu_pkg::cell_t s3_cell_q;

  // stage 4
  emcu_pkg::frac_sel_e        s4_sel_d, s4_sel_q;
  emcu_pkg::word_t            s4_diff;
  logic [emcu_pkg::CAP_W-1:0] s4_excess_q;
  emcu_pkg::cell_t            s4_cell_q;

  // Mode 1 above Ts: liquid capacity on (T - Ts), solidus enthalpy added later
  always_comb begin
    t_ext  = {temperature_i[emcu_pkg::WORD_W-1], temperature_i};
    ts_ext = {cfg_i.solidus[emcu_pkg::WORD_W-1], cfg_i.solidus};
    tdiff  = t_ext - ts_ext;
    if (!cfg_i.mode) begin
      s1_cap_d    = cfg_i.cap_liq;
      s1_mul_d    = t_ext;
      s1_add_hs_d = 1'b0;
    end else if (tdiff[emcu_pkg::WORD_W]) begin
      s1_cap_d    = cfg_i.cap_sol;
      s1_mul_d    = t_ext;
      s1_add_hs_d = 1'b0;
    end else begin
      s1_cap_d    = cfg_i.cap_liq;
      s1_mul_d    = tdiff;
      s1_add_hs_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      s1_cap_q    <= s1_cap_d;
      s1_mul_q    <= s1_mul_d;
      s1_add_hs_q <= s1_add_hs_d;
      s1_cell_q   <= cell_i;
    end
  end

  always_comb begin
    hs_cap  = cfg_i.mode ? cfg_i.cap_sol : cfg_i.cap_liq;
    h_prod  = emcu_pkg::prod_t'($signed({1'b0, s1_cap_q})) * emcu_pkg::prod_t'(s1_mul_q);
    hs_prod = emcu_pkg::prod_t'($signed({1'b0, hs_cap})) * emcu_pkg::prod_t'(cfg_i.solidus);
    lf_prod = emcu_pkg::prod_t'($signed({1'b0, cfg_i.latent}))
            * emcu_pkg::prod_t'($signed({1'b0, s1_cell_q.fold}));
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      s2_h_q      <= emcu_pkg::fix_rescale(h_prod);
      s2_hs_q     <= emcu_pkg::fix_rescale(hs_prod);
      s2_lf_q     <= emcu_pkg::fix_rescale(lf_prod);
      s2_add_hs_q <= s1_add_hs_q;
      s2_cell_q   <= s1_cell_q;
    end
  end

  always_comb begin
    hs_part = s2_add_hs_q ? s2_hs_q : '0;
    s3_h_d  = s2_h_q + hs_part + s2_lf_q;
    s3_hl_d = s2_hs_q + emcu_pkg::word_t'({1'b0, cfg_i.latent});
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[2]) begin
      s3_h_q    <= s3_h_d;
      s3_hs_q   <= s2_hs_q;
      s3_hl_q   <= s3_hl_d;
      s3_cell_q <= s2_cell_q;
    end
  end

  // Compares use the wrapped liquidus as is
  always_comb begin
    s4_diff = s3_h_q - s3_hs_q;
    if (s3_h_q < s3_hs_q) begin
      s4_sel_d = emcu_pkg::FR_ZERO;
    end else if (s3_h_q > s3_hl_q) begin
      s4_sel_d = emcu_pkg::FR_FULL;
    end else begin
      s4_sel_d = emcu_pkg::FR_INTERP;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[3]) begin
      s4_sel_q    <= s4_sel_d;
      s4_excess_q <= s4_diff[emcu_pkg::CAP_W-1:0];
      s4_cell_q   <= s3_cell_q;
    end
  end

  assign sel_o    = s4_sel_q;
  assign excess_o = s4_excess_q;
  assign cell_o   = s4_cell_q;

endmodule

@@ hdl/emcu_fraction.sv @@
// Stages 5-6: scale the enthalpy excess by 1/Lf and clamp to the new liquid fraction.
module emcu_fraction (
  input  logic                                 clk_i,
  input  logic [emcu_pkg::FRAC_STAGES-1:0]     adv_i,
  input  emcu_pkg::cfg_t                       cfg_i,
  input  emcu_pkg::frac_sel_e                  sel_i,
  input  logic [emcu_pkg::CAP_W-1:0]           excess_i,
  input  emcu_pkg::cell_t                      cell_i,
  output logic [emcu_pkg::FRAC_W-1:0]          fn_o,
  output emcu_pkg::cell_t                      cell_o
);

  emcu_pkg::ratio_t            ratio_full;
  emcu_pkg::quot_t             s5_quot_q;
  emcu_pkg::frac_sel_e         s5_sel_q;
  emcu_pkg::cell_t             s5_cell_q;
  logic [emcu_pkg::FRAC_W-1:0] s6_fn_d, s6_fn_q;
  emcu_pkg::cell_t             s6_cell_q;

  assign ratio_full = emcu_pkg::ratio_t'(excess_i) * emcu_pkg::ratio_t'(cfg_i.inv_latent);

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      s5_quot_q <= ratio_full[emcu_pkg::RATIO_W-1:emcu_pkg::FRAC_BITS];
      s5_sel_q  <= sel_i;
      s5_cell_q <= cell_i;
    end
  end

  // reciprocal may overshoot one
  always_comb begin
    unique case (s5_sel_q)
      emcu_pkg::FR_ZERO:   s6_fn_d = '0;
      emcu_pkg::FR_FULL:   s6_fn_d = emcu_pkg::FRAC_ONE;
      emcu_pkg::FR_INTERP: begin
        if (s5_quot_q > emcu_pkg::quot_t'(emcu_pkg::FRAC_ONE)) begin
          s6_fn_d = emcu_pkg::FRAC_ONE;
        end else begin
          s6_fn_d = s5_quot_q[emcu_pkg::FRAC_W-1:0];
        end
      end
      default:             s6_fn_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      s6_fn_q   <= s6_fn_d;
      s6_cell_q <= s5_cell_q;
    end
  end

  assign fn_o   = s6_fn_q;
  assign cell_o = s6_cell_q;

endmodule

@@ hdl/emcu_update.sv @@
// Stages 7-10: heat source correction, fraction-weighted force and drag penalization.
module emcu_update (
  input  logic                                 clk_i,
  input  logic [emcu_pkg::UPD_STAGES-1:0]      adv_i,
  input  emcu_pkg::cfg_t                       cfg_i,
  input  logic [emcu_pkg::FRAC_W-1:0]          fn_i,
  input  emcu_pkg::cell_t                      cell_i,
  output logic [emcu_pkg::FRAC_W-1:0]          fraction_o,
  output emcu_pkg::word_t                      heat_source_o,
  output emcu_pkg::word_t [2:0]                force_o
);

  // stage 7
  emcu_pkg::sq_t                  sq_full;
  logic signed [emcu_pkg::FRAC_W:0] dfrac;
  emcu_pkg::prod_t                gain_prod;
  emcu_pkg::prod_t [2:0]          frc_prod;
  logic [emcu_pkg::FRAC_W-1:0]    s7_sq_q, s7_fn_q;
  emcu_pkg::word_t                s7_gain_q;
  emcu_pkg::word_t [2:0]          s7_frc_q;
  emcu_pkg::cell_t                s7_cell_q;

  // stage 8
  logic [emcu_pkg::FRAC_W-1:0]    s8_damp_q, s8_fn_q;
  emcu_pkg::word_t                s8_src_q;
  emcu_pkg::word_t [2:0]          s8_frc_q;
  emcu_pkg::cell_t                s8_cell_q;

  // stage 9
  emcu_pkg::prod_t [2:0]          drag_prod;
  emcu_pkg::word_t [2:0]          s9_drag_q, s9_frc_q, s9_fin_q;
  emcu_pkg::word_t                s9_src_q;
  logic [emcu_pkg::FRAC_W-1:0]    s9_fn_q;

  // stage 10
  emcu_pkg::word_t [2:0]          s10_force_d, s10_force_q;
  emcu_pkg::word_t                s10_src_q;
  logic [emcu_pkg::FRAC_W-1:0]    s10_fn_q;

  always_comb begin
    sq_full   = emcu_pkg::sq_t'(fn_i) * emcu_pkg::sq_t'(fn_i);
    dfrac     = $signed({1'b0, fn_i}) - $signed({1'b0, cell_i.fold});
    gain_prod = emcu_pkg::prod_t'(cfg_i.gain) * emcu_pkg::prod_t'(dfrac);
    for (int i = 0; i < 3; i++) begin
      frc_prod[i] = emcu_pkg::prod_t'($signed(cell_i.force_in[i]))
                  * emcu_pkg::prod_t'($signed({1'b0, fn_i}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      s7_sq_q   <= sq_full[emcu_pkg::FRAC_BITS +: emcu_pkg::FRAC_W];
      s7_gain_q <= emcu_pkg::fix_rescale(gain_prod);
      for (int i = 0; i < 3; i++) begin
        s7_frc_q[i] <= emcu_pkg::fix_rescale(frc_prod[i]);
      end
      s7_fn_q   <= fn_i;
      s7_cell_q <= cell_i;
    end
  end

  // fn*fn never exceeds one, so the damping stays in [0, 1]
  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      s8_damp_q <= emcu_pkg::FRAC_ONE - s7_sq_q;
      s8_src_q  <= s7_cell_q.src - s7_gain_q;
      s8_frc_q  <= s7_frc_q;
      s8_fn_q   <= s7_fn_q;
      s8_cell_q <= s7_cell_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      drag_prod[i] = emcu_pkg::prod_t'($signed({1'b0, s8_damp_q}))
                   * emcu_pkg::prod_t'($signed(s8_cell_q.vel[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[2]) begin
      for (int i = 0; i < 3; i++) begin
        s9_drag_q[i] <= emcu_pkg::fix_rescale(drag_prod[i]);
      end
      s9_frc_q <= s8_frc_q;
      s9_fin_q <= s8_cell_q.force_in;
      s9_src_q <= s8_src_q;
      s9_fn_q  <= s8_fn_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s10_force_d[i] = cfg_i.drag ? (s9_frc_q[i] - s9_drag_q[i]) : s9_fin_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[3]) begin
      s10_force_q <= s10_force_d;
      s10_src_q   <= s9_src_q;
      s10_fn_q    <= s9_fn_q;
    end
  end

  assign fraction_o    = s10_fn_q;
  assign heat_source_o = s10_src_q;
  assign force_o       = s10_force_q;

endmodule

@@ hdl/enthalpy_melting_cell_update_unit.sv @@
// Top level of the enthalpy-method melt update: config registers, beat flow control, stages.
//
// Takes one lattice cell per beat and returns its new liquid fraction, corrected heat source
// and updated force. The datapath is a ten-stage register pipeline (capacity select, enthalpy
// products, enthalpy sum, phase compare, 1/Lf scaling, clamp, source and force products,
// damping, drag products, final subtract), and a new beat can be taken every cycle unless the
// input is stalled. Each stage holds its beat while the one after it is full and stalled;
// empty stages close up, so input is stalled only when every stage holds a beat and the
// output beat is not taken. Values are Q16.16 with wrap-around, the fraction is Q1.16.
// Configuration writes take effect at once and must be made while no beat is in flight.
module enthalpy_melting_cell_update_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                cfg_we_i,
  input  logic [emcu_pkg::IDX_W-1:0]          cfg_index_i,
  input  logic [emcu_pkg::WORD_W-1:0]         cfg_data_i,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [emcu_pkg::WORD_W-1:0]  temperature_i,
  input  logic [emcu_pkg::FRAC_W-1:0]         fraction_before_i,
  input  logic signed [emcu_pkg::WORD_W-1:0]  heat_source_in_i,
  input  logic signed [emcu_pkg::WORD_W-1:0]  force_x_in_i,
  input  logic signed [emcu_pkg::WORD_W-1:0]  force_y_in_i,
  input  logic signed [emcu_pkg::WORD_W-1:0]  force_z_in_i,
  input  logic signed [emcu_pkg::WORD_W-1:0]  velocity_x_i,
  input  logic signed [emcu_pkg::WORD_W-1:0]  velocity_y_i,
  input  logic signed [emcu_pkg::WORD_W-1:0]  velocity_z_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [emcu_pkg::FRAC_W-1:0]         fraction_after_o,
  output logic signed [emcu_pkg::WORD_W-1:0]  heat_source_out_o,
  output logic signed [emcu_pkg::WORD_W-1:0]  force_x_out_o,
  output logic signed [emcu_pkg::WORD_W-1:0]  force_y_out_o,
  output logic signed [emcu_pkg::WORD_W-1:0]  force_z_out_o
);

  emcu_pkg::cfg_t                        cfg_q;
  logic [emcu_pkg::NUM_STAGES-1:0]       vld_d, vld_q, adv;
  emcu_pkg::cell_t                       cell_in, enth_cell, frac_cell;
  emcu_pkg::frac_sel_e                   enth_sel;
  logic [emcu_pkg::CAP_W-1:0]            enth_excess;
  logic [emcu_pkg::FRAC_W-1:0]           frac_fn;
  emcu_pkg::word_t [2:0]                 upd_force;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cap_liq    <= emcu_pkg::CAP_ONE;
      cfg_q.cap_sol    <= emcu_pkg::CAP_ONE;
      cfg_q.latent     <= emcu_pkg::CAP_ONE;
      cfg_q.inv_latent <= emcu_pkg::CAP_ONE;
      cfg_q.solidus    <= '0;
      cfg_q.gain       <= emcu_pkg::word_t'(emcu_pkg::CAP_ONE);
      cfg_q.mode       <= 1'b0;
      cfg_q.drag       <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (emcu_pkg::cfg_reg_e'(cfg_index_i))
        emcu_pkg::REG_CAP_LIQ:    cfg_q.cap_liq    <= cfg_data_i[emcu_pkg::CAP_W-1:0];
        emcu_pkg::REG_CAP_SOL:    cfg_q.cap_sol    <= cfg_data_i[emcu_pkg::CAP_W-1:0];
        emcu_pkg::REG_LATENT:     cfg_q.latent     <= cfg_data_i[emcu_pkg::CAP_W-1:0];
        emcu_pkg::REG_INV_LATENT: cfg_q.inv_latent <= cfg_data_i[emcu_pkg::CAP_W-1:0];
        emcu_pkg::REG_SOLIDUS:    cfg_q.solidus    <= emcu_pkg::word_t'(cfg_data_i);
        emcu_pkg::REG_GAIN:       cfg_q.gain       <= emcu_pkg::word_t'(cfg_data_i);
        emcu_pkg::REG_MODE:       cfg_q.mode       <= cfg_data_i[0];
        emcu_pkg::REG_DRAG:       cfg_q.drag       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its beat moves on
  always_comb begin
    adv[emcu_pkg::NUM_STAGES-1] = !vld_q[emcu_pkg::NUM_STAGES-1] || !out_stall_i;
    for (int k = emcu_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    vld_d[0] = adv[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < emcu_pkg::NUM_STAGES; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[emcu_pkg::NUM_STAGES-1];

  always_comb begin
    cell_in.fold        = fraction_before_i;
    cell_in.src         = heat_source_in_i;
    cell_in.force_in[0] = force_x_in_i;
    cell_in.force_in[1] = force_y_in_i;
    cell_in.force_in[2] = force_z_in_i;
    cell_in.vel[0]      = velocity_x_i;
    cell_in.vel[1]      = velocity_y_i;
    cell_in.vel[2]      = velocity_z_i;
  end

  emcu_enthalpy u_enthalpy (
    .clk_i         (clk_i),
    .adv_i         (adv[emcu_pkg::ENTH_STAGES-1:0]),
    .cfg_i         (cfg_q),
    .temperature_i (temperature_i),
    .cell_i        (cell_in),
    .sel_o         (enth_sel),
    .excess_o      (enth_excess),
    .cell_o        (enth_cell)
  );

  emcu_fraction u_fraction (
    .clk_i    (clk_i),
    .adv_i    (adv[emcu_pkg::ENTH_STAGES+emcu_pkg::FRAC_STAGES-1:emcu_pkg::ENTH_STAGES]),
    .cfg_i    (cfg_q),
    .sel_i    (enth_sel),
    .excess_i (enth_excess),
    .cell_i   (enth_cell),
    .fn_o     (frac_fn),
    .cell_o   (frac_cell)
  );

  emcu_update u_update (
    .clk_i         (clk_i),
    .adv_i         (adv[emcu_pkg::NUM_STAGES-1:emcu_pkg::ENTH_STAGES+emcu_pkg::FRAC_STAGES]),
    .cfg_i         (cfg_q),
    .fn_i          (frac_fn),
    .cell_i        (frac_cell),
    .fraction_o    (fraction_after_o),
    .heat_source_o (heat_source_out_o),
    .force_o       (upd_force)
  );

  assign force_x_out_o = upd_force[0];
  assign force_y_out_o = upd_force[1];
  assign force_z_out_o = upd_force[2];

`ifndef SYNTHESIS
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fraction_after_o <= emcu_pkg::FRAC_ONE))
    else $error("fraction_after above one");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && (&vld_q)) |-> in_stall_o)
    else $error("input taken while pipeline full and output stalled");

  a_beat_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (int'($countones(vld_q)) == int'($past($countones(vld_q)))
      + int'($past(in_valid_i && !in_stall_o)) - int'($past(out_valid_o && !out_stall_i))))
    else $error("beat lost or duplicated in pipeline");
`endif

endmodule
